@@ src/dtsc_pkg.sv @@
// Shared types and constants for the date and time set controller.
`timescale 1ns / 1ps

package dtsc_pkg;

  localparam int CMD_W    = 4;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int YEAR_W   = 8;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int SEL_W    = 3;
  localparam int STATUS_W = 2;

  localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
  localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;
  localparam logic [YEAR_W-1:0]   YEAR_MIN   = 8'd1;
  localparam logic [YEAR_W-1:0]   YEAR_MAX   = 8'd200;
  localparam logic [YEAR_W-1:0]   YEAR_RESET = 8'd100;
  localparam logic [MONTH_W-1:0]  MONTH_MAX  = 4'd11;
  localparam logic [DAY_W-1:0]    FEB_LEAP   = 5'd29;

  localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [CMD_W-1:0] {
    CMD_PREV_COL = 4'd0,
    CMD_NEXT_COL = 4'd1,
    CMD_ROW_UP   = 4'd2,
    CMD_ROW_DOWN = 4'd3,
    CMD_INC      = 4'd4,
    CMD_DEC      = 4'd5,
    CMD_OK       = 4'd6,
    CMD_CANCEL   = 4'd7,
    CMD_LOAD     = 4'd8
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CONTINUE  = 2'd0,
    ST_ACCEPTED  = 2'd1,
    ST_CANCELLED = 2'd2
  } status_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
  } dt_time_t;

  typedef struct packed {
    dt_time_t         t;
    logic [SEL_W-1:0] selection;
  } dt_state_t;

endpackage

@@ src/dtsc_in_if.sv @@
// Input channel carrying one command item and its load values.
`timescale 1ns / 1ps

interface dtsc_in_if;
  import dtsc_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [HOUR_W-1:0]   new_hour;
  logic [MINUTE_W-1:0] new_minute;
  logic [SECOND_W-1:0] new_second;
  logic [YEAR_W-1:0]   new_year;
  logic [MONTH_W-1:0]  new_month;
  logic [DAY_W-1:0]    new_day;

  modport source (
    output valid, cmd, new_hour, new_minute, new_second, new_year, new_month, new_day,
    input  ready
  );

  modport sink (
    input  valid, cmd, new_hour, new_minute, new_second, new_year, new_month, new_day,
    output ready
  );

endinterface

@@ src/dtsc_out_if.sv @@
// Output channel carrying one result item with the edited values and status.
`timescale 1ns / 1ps

interface dtsc_out_if;
  import dtsc_pkg::*;

  logic                valid;
  logic                ready;
  logic [HOUR_W-1:0]   hour_out;
  logic [MINUTE_W-1:0] minute_out;
  logic [SECOND_W-1:0] second_out;
  logic [YEAR_W-1:0]   year_out;
  logic [MONTH_W-1:0]  month_out;
  logic [DAY_W-1:0]    day_out;
  logic [SEL_W-1:0]    selection_out;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, hour_out, minute_out, second_out, year_out, month_out, day_out,
           selection_out, status,
    input  ready
  );

  modport sink (
    input  valid, hour_out, minute_out, second_out, year_out, month_out, day_out,
           selection_out, status,
    output ready
  );

endinterface

@@ src/dtsc_step.sv @@
// Next-state logic for one command: selection moves, field edits, load and status.
`timescale 1ns / 1ps

module dtsc_step (
  input  logic [dtsc_pkg::CMD_W-1:0] cmd,
  input  dtsc_pkg::dt_time_t         load_val,
  input  dtsc_pkg::dt_state_t        cur,
  input  logic                       date_enable,
  output dtsc_pkg::dt_state_t        nxt,
  output dtsc_pkg::status_t          status
);
  import dtsc_pkg::*;

  function automatic logic [YEAR_W-1:0] wrap_step(
    input logic [YEAR_W-1:0] v,
    input logic              up,
    input logic [YEAR_W-1:0] lo,
    input logic [YEAR_W-1:0] hi
  );
    if (up) begin
      return (v >= hi) ? lo : v + 8'd1;
    end
    return (v <= lo) ? hi : v - 8'd1;
  endfunction

  // Year is stored as an offset from 1900, so century years 1900 and 2100 are not leap.
  function automatic logic [DAY_W-1:0] month_len(
    input logic [YEAR_W-1:0]  y,
    input logic [MONTH_W-1:0] m
  );
    logic [MONTH_W-1:0] mc;
    logic               leap;
    mc   = (m > MONTH_MAX) ? MONTH_MAX : m;
    leap = (y[1:0] == 2'b00) && (y != 8'd0) && (y != YEAR_MAX);
    if (mc == 4'd1 && leap) begin
      return FEB_LEAP;
    end
    return MONTH_DAYS[mc];
  endfunction

  function automatic logic [DAY_W-1:0] clamp_day(
    input logic [DAY_W-1:0] d,
    input logic [DAY_W-1:0] n
  );
    if (d > n) begin
      return n;
    end
    if (d == 5'd0) begin
      return 5'd1;
    end
    return d;
  endfunction

  function automatic logic [SEL_W-1:0] sel_at(
    input logic [1:0]       row,
    input logic [1:0]       col,
    input logic [SEL_W-1:0] last,
    input logic [1:0]       last_row
  );
    logic [1:0] n_m1;
    logic [1:0] c;
    n_m1 = (row == last_row) ? 2'd1 : 2'd2;
    c    = (col > n_m1) ? n_m1 : col;
    if (row == last_row) begin
      return last + 3'd1 + {1'b0, c};
    end
    return ((row == 2'd1) ? 3'd3 : 3'd0) + {1'b0, c};
  endfunction

  logic [SEL_W-1:0] last;
  logic [1:0]       last_row;
  logic             in_field;
  logic [SEL_W-1:0] btn_off;
  logic [1:0]       row;
  logic [1:0]       col;
  logic [1:0]       n_m1;
  logic [1:0]       new_row;
  logic [1:0]       new_col;
  logic             up;
  dt_time_t         t;

  always_comb begin
    last     = date_enable ? 3'd5 : 3'd2;
    last_row = date_enable ? 2'd2 : 2'd1;
    in_field = (cur.selection <= last);
    btn_off  = cur.selection - last - 3'd1;
    if (in_field) begin
      row = (cur.selection >= 3'd3) ? 2'd1 : 2'd0;
      col = (cur.selection >= 3'd3) ? 2'(cur.selection - 3'd3) : 2'(cur.selection);
    end else begin
      row = last_row;
      col = (btn_off > 3'd1) ? 2'd1 : 2'(btn_off);
    end
    n_m1    = (row == last_row) ? 2'd1 : 2'd2;
    new_col = 2'(wrap_step({6'd0, col}, cmd == CMD_NEXT_COL, 8'd0, {6'd0, n_m1}));
    new_row = 2'(wrap_step({6'd0, row}, cmd == CMD_ROW_DOWN, 8'd0, {6'd0, last_row}));
    up      = (cmd == CMD_INC);

    nxt    = cur;
    status = ST_CONTINUE;
    t      = cur.t;

    case (cmd_t'(cmd))
      CMD_PREV_COL, CMD_NEXT_COL: begin
        nxt.selection = sel_at(row, new_col, last, last_row);
      end
      CMD_ROW_UP, CMD_ROW_DOWN: begin
        nxt.selection = sel_at(new_row, col, last, last_row);
      end
      CMD_INC, CMD_DEC: begin
        if (in_field) begin
          case (cur.selection)
            3'd0: t.hour = 5'(wrap_step({3'd0, t.hour}, up, 8'd0, {3'd0, HOUR_MAX}));
            3'd1: t.minute = 6'(wrap_step({2'd0, t.minute}, up, 8'd0, {2'd0, MINUTE_MAX}));
            3'd2: t.second = 6'(wrap_step({2'd0, t.second}, up, 8'd0, {2'd0, SECOND_MAX}));
            3'd3: t.year = wrap_step(t.year, up, YEAR_MIN, YEAR_MAX);
            3'd4: t.month = 4'(wrap_step({4'd0, t.month}, up, 8'd0, {4'd0, MONTH_MAX}));
            default: begin
              t.day = 5'(wrap_step({3'd0, t.day}, up, 8'd1,
                                   {3'd0, month_len(t.year, t.month)}));
            end
          endcase
          t.day = clamp_day(t.day, month_len(t.year, t.month));
          nxt.t = t;
        end
      end
      CMD_OK: begin
        status = (cur.selection == last + 3'd1) ? ST_CANCELLED : ST_ACCEPTED;
      end
      CMD_CANCEL: begin
        status = ST_CANCELLED;
      end
      CMD_LOAD: begin
        t.hour   = (load_val.hour > HOUR_MAX) ? HOUR_MAX : load_val.hour;
        t.minute = (load_val.minute > MINUTE_MAX) ? MINUTE_MAX : load_val.minute;
        t.second = (load_val.second > SECOND_MAX) ? SECOND_MAX : load_val.second;
        if (load_val.year < YEAR_MIN) begin
          t.year = YEAR_MIN;
        end else if (load_val.year > YEAR_MAX) begin
          t.year = YEAR_MAX;
        end else begin
          t.year = load_val.year;
        end
        t.month       = (load_val.month > MONTH_MAX) ? MONTH_MAX : load_val.month;
        t.day         = clamp_day(load_val.day, month_len(t.year, t.month));
        nxt.t         = t;
        nxt.selection = 3'd0;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

@@ src/date_time_set_controller_core.sv @@
// Top level of the button-driven time and date set controller.
`timescale 1ns / 1ps

// The block takes one command item per clock cycle and returns exactly one result item for
// each, in the cycle after the item is accepted. Each result carries the time, date, selected
// cell and status after that command. All of the work for a command is done in one pass of
// the next-state logic, which writes the edit registers and the result register at the same
// clock edge, so a new item is taken in every cycle in which the result register is empty or
// its item is being taken. The date_enable register should be written only while the block
// is idle; it resets to 1, which puts the date fields on the grid.
module date_time_set_controller_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        date_enable_we,
  input  logic        date_enable_data,
  dtsc_in_if.sink     in_ch,
  dtsc_out_if.source  out_ch
);
  import dtsc_pkg::*;

  dt_state_t state;
  dt_state_t state_next;
  dt_time_t  load_val;
  status_t   status_next;
  logic      date_enable;
  logic      out_valid;
  dt_state_t res_state;
  status_t   res_status;
  logic      accept;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign load_val.hour   = in_ch.new_hour;
  assign load_val.minute = in_ch.new_minute;
  assign load_val.second = in_ch.new_second;
  assign load_val.year   = in_ch.new_year;
  assign load_val.month  = in_ch.new_month;
  assign load_val.day    = in_ch.new_day;

  dtsc_step u_step (
    .cmd         (in_ch.cmd),
    .load_val    (load_val),
    .cur         (state),
    .date_enable (date_enable),
    .nxt         (state_next),
    .status      (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.t.hour   <= '0;
      state.t.minute <= '0;
      state.t.second <= '0;
      state.t.year   <= YEAR_RESET;
      state.t.month  <= '0;
      state.t.day    <= 5'd1;
      state.selection <= '0;
      date_enable    <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (date_enable_we) begin
        date_enable <= date_enable_data;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_state  <= state_next;
      res_status <= status_next;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.hour_out      = res_state.t.hour;
  assign out_ch.minute_out    = res_state.t.minute;
  assign out_ch.second_out    = res_state.t.second;
  assign out_ch.year_out      = res_state.t.year;
  assign out_ch.month_out     = res_state.t.month;
  assign out_ch.day_out       = res_state.t.day;
  assign out_ch.selection_out = res_state.selection;
  assign out_ch.status        = res_status;

endmodule

@@ src/dtsc_checker.sv @@
// Port-level checks for the set controller and the bind that attaches them.
`timescale 1ns / 1ps

module dtsc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [dtsc_pkg::CMD_W-1:0]    cmd,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dtsc_pkg::HOUR_W-1:0]   hour_out,
  input logic [dtsc_pkg::MINUTE_W-1:0] minute_out,
  input logic [dtsc_pkg::SECOND_W-1:0] second_out,
  input logic [dtsc_pkg::DAY_W-1:0]    day_out,
  input logic [dtsc_pkg::SEL_W-1:0]    selection_out,
  input logic [dtsc_pkg::STATUS_W-1:0] status
);
  import dtsc_pkg::*;

  // A stalled result item must hold its place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(selection_out) && $stable(status))
    else $error("result item changed while stalled");

  // Every accepted item gives a result item in the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result item");

  // A load selects the first field and reports continue.
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_LOAD |=>
      selection_out == 3'd0 && status == ST_CONTINUE)
    else $error("load did not select the first field");

  // Reported values stay within their ranges.
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hour_out <= HOUR_MAX && minute_out <= MINUTE_MAX &&
      second_out <= SECOND_MAX && day_out != 5'd0 && status != 2'd3)
    else $error("result value out of range");

endmodule

bind date_time_set_controller_core dtsc_checker u_dtsc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .cmd           (in_ch.cmd),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .hour_out      (out_ch.hour_out),
  .minute_out    (out_ch.minute_out),
  .second_out    (out_ch.second_out),
  .day_out       (out_ch.day_out),
  .selection_out (out_ch.selection_out),
  .status        (out_ch.status)
);

@@ verif/dtsc_result_check.sv @@
// Checker that predicts every result of the time and date set controller and compares it.
`timescale 1ns / 1ps

module dtsc_result_check (
  input  logic clk,
  input  logic rst,
  input  logic date_enable_we,
  input  logic date_enable_data,
  dtsc_in_if   in_ch,
  dtsc_out_if  out_ch,
  output int   errors,
  output int   pending,
  output int   results,
  output int   accepts,
  output int   cancels
);
  import dtsc_pkg::*;

  localparam int SEL_HOUR     = 0;
  localparam int SEL_MINUTE   = 1;
  localparam int SEL_SECOND   = 2;
  localparam int SEL_YEAR     = 3;
  localparam int SEL_MONTH    = 4;
  localparam int SEL_DAY      = 5;
  localparam int ROW_CELLS    = 3;
  localparam int BUTTON_CELLS = 2;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    dt_state_t           st;
    logic [STATUS_W-1:0] status;
  } reading_t;

  dt_state_t cur;
  logic      de;
  reading_t  want_q[$];

  assign pending = want_q.size();

  function automatic int month_length(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m);
    int full;
    full = int'(y) + 1900;
    if (m == 1 && (((full % 4) == 0 && (full % 100) != 0) || (full % 400) == 0)) begin
      return FEB_LEAP;
    end
    return MONTH_DAYS[(m > MONTH_MAX) ? MONTH_MAX : m];
  endfunction

  function automatic int wrap_move(int v, bit up, int lo, int hi);
    if (up) begin
      return (v >= hi) ? lo : v + 1;
    end
    return (v <= lo) ? hi : v - 1;
  endfunction

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) begin
      return lo;
    end
    return (v > hi) ? hi : v;
  endfunction

  function automatic int top_field();
    return de ? SEL_DAY : SEL_SECOND;
  endfunction

  function automatic int row_total();
    return de ? 3 : 2;
  endfunction

  function automatic int row_of(int sel);
    return (sel <= top_field()) ? sel / ROW_CELLS : row_total() - 1;
  endfunction

  function automatic int col_of(int sel);
    int c;
    if (sel <= top_field()) begin
      return sel % ROW_CELLS;
    end
    c = sel - (top_field() + 1);
    return (c > 1) ? 1 : c;
  endfunction

  function automatic int cells_in(int row);
    return (row == row_total() - 1) ? BUTTON_CELLS : ROW_CELLS;
  endfunction

  function automatic int cell_at(int row, int col);
    int n;
    n = cells_in(row);
    if (col >= n) begin
      col = n - 1;
    end
    return (row == row_total() - 1) ? top_field() + 1 + col : row * ROW_CELLS + col;
  endfunction

  function automatic void clamp_day();
    int n;
    n = month_length(cur.t.year, cur.t.month);
    cur.t.day = DAY_W'(clip(int'(cur.t.day), 1, n));
  endfunction

  function automatic reading_t step_editor(logic [CMD_W-1:0] c);
    reading_t r;
    int       row;
    int       col;
    int       sel;
    bit       up;
    status_t  st;
    sel = int'(cur.selection);
    st  = ST_CONTINUE;
    case (c)
      CMD_PREV_COL, CMD_NEXT_COL: begin
        row = row_of(sel);
        col = wrap_move(col_of(sel), c == CMD_NEXT_COL, 0, cells_in(row) - 1);
        cur.selection = SEL_W'(cell_at(row, col));
      end
      CMD_ROW_UP, CMD_ROW_DOWN: begin
        col = col_of(sel);
        row = wrap_move(row_of(sel), c == CMD_ROW_DOWN, 0, row_total() - 1);
        cur.selection = SEL_W'(cell_at(row, col));
      end
      CMD_INC, CMD_DEC: begin
        if (sel <= top_field()) begin
          up = (c == CMD_INC);
          case (sel)
            SEL_HOUR:   cur.t.hour   = HOUR_W'(wrap_move(cur.t.hour, up, 0, HOUR_MAX));
            SEL_MINUTE: cur.t.minute = MINUTE_W'(wrap_move(cur.t.minute, up, 0, MINUTE_MAX));
            SEL_SECOND: cur.t.second = SECOND_W'(wrap_move(cur.t.second, up, 0, SECOND_MAX));
            SEL_YEAR:   cur.t.year   = YEAR_W'(wrap_move(cur.t.year, up, YEAR_MIN, YEAR_MAX));
            SEL_MONTH:  cur.t.month  = MONTH_W'(wrap_move(cur.t.month, up, 0, MONTH_MAX));
            default: begin
              cur.t.day = DAY_W'(wrap_move(cur.t.day, up, 1,
                                           month_length(cur.t.year, cur.t.month)));
            end
          endcase
          clamp_day();
        end
      end
      CMD_OK: st = (sel == top_field() + 1) ? ST_CANCELLED : ST_ACCEPTED;
      CMD_CANCEL: st = ST_CANCELLED;
      CMD_LOAD: begin
        cur.t.hour    = HOUR_W'(clip(int'(in_ch.new_hour), 0, HOUR_MAX));
        cur.t.minute  = MINUTE_W'(clip(int'(in_ch.new_minute), 0, MINUTE_MAX));
        cur.t.second  = SECOND_W'(clip(int'(in_ch.new_second), 0, SECOND_MAX));
        cur.t.year    = YEAR_W'(clip(int'(in_ch.new_year), YEAR_MIN, YEAR_MAX));
        cur.t.month   = MONTH_W'(clip(int'(in_ch.new_month), 0, MONTH_MAX));
        cur.t.day     = in_ch.new_day;
        clamp_day();
        cur.selection = '0;
      end
      default: ;
    endcase
    r.st     = cur;
    r.status = st;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    errors++;
  endtask

  task automatic check_result();
    reading_t got;
    reading_t want;
    got.st.t.hour    = out_ch.hour_out;
    got.st.t.minute  = out_ch.minute_out;
    got.st.t.second  = out_ch.second_out;
    got.st.t.year    = out_ch.year_out;
    got.st.t.month   = out_ch.month_out;
    got.st.t.day     = out_ch.day_out;
    got.st.selection = out_ch.selection_out;
    got.status       = out_ch.status;
    if (want_q.size() == 0) begin
      report_mismatch("result item with no command item waiting");
      return;
    end
    want = want_q.pop_front();
    results++;
    if (got.status == ST_ACCEPTED) accepts++;
    if (got.status == ST_CANCELLED) cancels++;
    if (got.st.t.hour !== want.st.t.hour)
      report_mismatch($sformatf("hour %0d, want %0d", got.st.t.hour, want.st.t.hour));
    if (got.st.t.minute !== want.st.t.minute)
      report_mismatch($sformatf("minute %0d, want %0d", got.st.t.minute, want.st.t.minute));
    if (got.st.t.second !== want.st.t.second)
      report_mismatch($sformatf("second %0d, want %0d", got.st.t.second, want.st.t.second));
    if (got.st.t.year !== want.st.t.year)
      report_mismatch($sformatf("year %0d, want %0d", got.st.t.year, want.st.t.year));
    if (got.st.t.month !== want.st.t.month)
      report_mismatch($sformatf("month %0d, want %0d", got.st.t.month, want.st.t.month));
    if (got.st.t.day !== want.st.t.day)
      report_mismatch($sformatf("day %0d, want %0d", got.st.t.day, want.st.t.day));
    if (got.st.selection !== want.st.selection)
      report_mismatch($sformatf("selection %0d, want %0d", got.st.selection,
                                want.st.selection));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
  endtask

  initial begin
    errors  = 0;
    results = 0;
    accepts = 0;
    cancels = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      cur.t.hour    = '0;
      cur.t.minute  = '0;
      cur.t.second  = '0;
      cur.t.year    = YEAR_RESET;
      cur.t.month   = '0;
      cur.t.day     = DAY_W'(1);
      cur.selection = '0;
      de            = 1'b1;
      want_q.delete();
    end else begin
      if (date_enable_we) de = date_enable_data;
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) want_q.push_back(step_editor(in_ch.cmd));
    end
  end

endmodule

@@ verif/testbench.sv @@
// Top of the testbench: clock, reset, command stimulus, pacing and the final verdict.
`timescale 1ns / 1ps

module testbench;
  import dtsc_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int SEGMENTS     = 6;
  localparam int SEGMENT_LEN  = 87;
  localparam int SETTLE_TICKS = 3;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
  } cmd_item_t;

  logic clk     = 1'b0;
  logic rst     = 1'b1;
  logic de_we   = 1'b0;
  logic de_data = 1'b0;

  int send_idle_pct  = 7;
  int recv_stall_pct = 75;
  int n_sent         = 0;
  int quiet          = 0;
  int chk_errors;
  int chk_pending;
  int chk_results;
  int chk_accepts;
  int chk_cancels;

  dtsc_in_if  cmd_ch ();
  dtsc_out_if res_ch ();

  date_time_set_controller_core dut (
    .clk              (clk),
    .rst              (rst),
    .date_enable_we   (de_we),
    .date_enable_data (de_data),
    .in_ch            (cmd_ch),
    .out_ch           (res_ch)
  );

  dtsc_result_check result_check (
    .clk              (clk),
    .rst              (rst),
    .date_enable_we   (de_we),
    .date_enable_data (de_data),
    .in_ch            (cmd_ch),
    .out_ch           (res_ch),
    .errors           (chk_errors),
    .pending          (chk_pending),
    .results          (chk_results),
    .accepts          (chk_accepts),
    .cancels          (chk_cancels)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    cmd_ch.valid      = 1'b0;
    cmd_ch.cmd        = '0;
    cmd_ch.new_hour   = '0;
    cmd_ch.new_minute = '0;
    cmd_ch.new_second = '0;
    cmd_ch.new_year   = '0;
    cmd_ch.new_month  = '0;
    cmd_ch.new_day    = '0;
    res_ch.ready      = 1'b0;
  end

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Timed out with %0d results still outstanding.", chk_pending);
      $display("FAIL date_time_set_controller_core");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic cmd_item_t plain_cmd(logic [CMD_W-1:0] c);
    cmd_item_t it;
    it     = cmd_item_t'($bits(cmd_item_t)'({$urandom, $urandom}));
    it.cmd = c;
    return it;
  endfunction

  function automatic cmd_item_t load_cmd(int h, int m, int s, int y, int mo, int d);
    cmd_item_t it;
    it.cmd    = CMD_LOAD;
    it.hour   = HOUR_W'(h);
    it.minute = MINUTE_W'(m);
    it.second = SECOND_W'(s);
    it.year   = YEAR_W'(y);
    it.month  = MONTH_W'(mo);
    it.day    = DAY_W'(d);
    return it;
  endfunction

  function automatic int pick_value(int lo, int hi, int w);
    int r;
    r = $urandom_range(99, 0);
    if (r < 10) return lo;
    if (r < 20) return hi;
    if (r < 35) return $urandom_range((1 << w) - 1, 0);
    return $urandom_range(hi, lo);
  endfunction

  function automatic cmd_item_t random_item();
    int r;
    int mo;
    int d;
    r = $urandom_range(99, 0);
    if (r < 10) begin
      mo = ($urandom_range(99, 0) < 30) ? 1 : pick_value(0, MONTH_MAX, MONTH_W);
      d  = ($urandom_range(99, 0) < 35) ? $urandom_range(31, 28) : pick_value(1, 31, DAY_W);
      return load_cmd(pick_value(0, HOUR_MAX, HOUR_W), pick_value(0, MINUTE_MAX, MINUTE_W),
                      pick_value(0, SECOND_MAX, SECOND_W),
                      pick_value(YEAR_MIN, YEAR_MAX, YEAR_W), mo, d);
    end
    if (r < 13) return plain_cmd(CMD_OK);
    if (r < 15) return plain_cmd(CMD_CANCEL);
    if (r < 18) return plain_cmd(CMD_W'($urandom_range((1 << CMD_W) - 1, int'(CMD_LOAD) + 1)));
    if (r < 48) return plain_cmd(CMD_W'($urandom_range(int'(CMD_ROW_DOWN), int'(CMD_PREV_COL))));
    return plain_cmd(($urandom_range(1, 0) == 1) ? CMD_INC : CMD_DEC);
  endfunction

  task automatic offer(input cmd_item_t it);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.cmd        <= it.cmd;
    cmd_ch.new_hour   <= it.hour;
    cmd_ch.new_minute <= it.minute;
    cmd_ch.new_second <= it.second;
    cmd_ch.new_year   <= it.year;
    cmd_ch.new_month  <= it.month;
    cmd_ch.new_day    <= it.day;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(negedge clk);
    while (chk_pending != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic set_date_mode(input logic value);
    drain();
    de_we   <= 1'b1;
    de_data <= value;
    @(posedge clk);
    de_we   <= 1'b0;
  endtask

  initial begin
    int        count;
    int        len;
    cmd_item_t it;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_date_mode(1'b1);

    offer(plain_cmd(CMD_OK));
    offer(plain_cmd(CMD_DEC));
    offer(plain_cmd(CMD_INC));
    offer(load_cmd(31, 63, 63, 255, 15, 31));
    offer(load_cmd(0, 0, 0, 0, 0, 0));
    offer(load_cmd(12, 30, 30, 100, 1, 31));
    offer(load_cmd(0, 0, 0, 200, 1, 30));
    offer(load_cmd(HOUR_MAX, MINUTE_MAX, SECOND_MAX, YEAR_MAX, 0, 31));
    offer(plain_cmd(CMD_INC));
    offer(plain_cmd(CMD_PREV_COL));
    offer(plain_cmd(CMD_INC));
    offer(plain_cmd(CMD_NEXT_COL));
    offer(plain_cmd(CMD_ROW_DOWN));
    offer(plain_cmd(CMD_INC));
    offer(plain_cmd(CMD_DEC));
    offer(plain_cmd(CMD_NEXT_COL));
    offer(plain_cmd(CMD_INC));
    offer(plain_cmd(CMD_ROW_DOWN));
    offer(plain_cmd(CMD_INC));
    offer(plain_cmd(CMD_PREV_COL));
    offer(plain_cmd(CMD_OK));
    offer(plain_cmd(CMD_CANCEL));
    offer(plain_cmd(CMD_W'((1 << CMD_W) - 1)));
    offer(plain_cmd(CMD_NEXT_COL));

    // The selection now sits on OK, which lies past the grid once the date row is gone.
    set_date_mode(1'b0);
    offer(plain_cmd(CMD_OK));
    offer(plain_cmd(CMD_NEXT_COL));
    offer(plain_cmd(CMD_DEC));

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct  = 7;
          recv_stall_pct = 75;
        end
        1: begin
          send_idle_pct  = 75;
          recv_stall_pct = 7;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      set_date_mode((seg % 2) == 0);
      count = 0;
      while (count < SEGMENT_LEN) begin
        if ($urandom_range(99, 0) < 8) begin
          len = $urandom_range(70, 2);
          if (len > SEGMENT_LEN - count) len = SEGMENT_LEN - count;
          it  = plain_cmd(($urandom_range(1, 0) == 1) ? CMD_INC : CMD_DEC);
          for (int k = 0; k < len; k++) begin
            offer(plain_cmd(it.cmd));
          end
          count += len;
        end else begin
          offer(random_item());
          count++;
        end
      end
    end

    drain();
    repeat (5) @(posedge clk);
    $display("Sent %0d command items and checked %0d results (%0d accepted, %0d cancelled).",
             n_sent, chk_results, chk_accepts, chk_cancels);
    $display("Both date modes and three pacing phases were run; %0d mismatches found.",
             chk_errors);
    if (chk_errors == 0) begin
      $display("PASS date_time_set_controller_core");
    end else begin
      $display("FAIL date_time_set_controller_core");
    end
    $finish;
  end

endmodule
